// File: hw/rtl/plc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// plc_pkg
// Shared widths, codes and controller/datapath command types.
// ----------------------------------------------------------------------------
package plc_pkg;

   localparam int BINS_DEFAULT = 64;

   localparam int ACT_W    = 3;
   localparam int PHASE_W  = 17;
   localparam int ERR_W    = 24;
   localparam int IDX_W    = 6;
   localparam int PROF_W   = 24;
   localparam int SUM_W    = 40;
   localparam int NUM_W    = 16;
   localparam int MEAN_W   = 24;
   localparam int RATE_W   = 16;
   localparam int SMOOTH_W = 16;
   localparam int NORM_W   = 23;
   localparam int ITER_W   = 32;
   localparam int SQRT_W   = 48;
   localparam int REQ_W    = 48;
   localparam int RSP_W    = 80;
   localparam int CSR_A_W  = 2;
   localparam int CSR_D_W  = 24;

   localparam logic [PHASE_W-1:0] PHASE_ONE = 17'h10000;
   localparam logic [NORM_W-1:0]  NORM_MAX  = 23'h7FFFFF;

   typedef logic [ACT_W-1:0] action_type;
   localparam action_type ACT_BEGIN   = 3'd0;
   localparam action_type ACT_SAMPLE  = 3'd1;
   localparam action_type ACT_DISCARD = 3'd2;
   localparam action_type ACT_END     = 3'd3;
   localparam action_type ACT_QUERY   = 3'd4;
   localparam action_type ACT_READ    = 3'd5;
   localparam action_type ACT_CLEAR   = 3'd6;

   typedef logic [CSR_A_W-1:0] csr_addr_type;
   localparam csr_addr_type CSR_RATE   = 2'd0;
   localparam csr_addr_type CSR_LOW    = 2'd1;
   localparam csr_addr_type CSR_HIGH   = 2'd2;
   localparam csr_addr_type CSR_SMOOTH = 2'd3;

   typedef enum logic [1:0] {
      RD_BIN  = 2'd0,
      RD_IDX  = 2'd1,
      RD_CNT  = 2'd2,
      RD_NEXT = 2'd3
   } rd_sel_type;

   typedef struct packed {
      logic       load_req;
      logic       cnt_clr;
      logic       cnt_inc;
      logic       rd_en;
      rd_sel_type rd_sel;
      logic       wr_wipe;
      logic       wr_zero;
      logic       wr_acc;
      logic       wr_upd;
      logic       wr_smooth;
      logic       div_start;
      logic       div_norm;
      logic       mean_load;
      logic       mul_load;
      logic       acc_clr;
      logic       sqrt_start;
      logic       norm_load;
      logic       sm_init;
      logic       sm_mul;
      logic       iter_inc;
      logic       rec_set;
      logic       rec_clr;
      logic       state_clr;
      logic       rsp_load;
   } plc_cmd_type;

   typedef struct packed {
      action_type act;
      logic       recording;
      logic       cnt_last;
      logic       num_zero;
      logic       obs_zero;
      logic       smooth_on;
      logic       div_busy;
      logic       div_done;
      logic       sqrt_done;
   } plc_sts_type;

endpackage
`default_nettype wire

// File: hw/rtl/plc_divider.sv
`default_nettype none
// ----------------------------------------------------------------------------
// plc_divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module plc_divider #(
   parameter int N = 48,
   parameter int D = 16
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         start,
   input  wire logic [N-1:0] dividend,
   input  wire logic [D-1:0] divisor,
   output logic              busy,
   output logic              done,
   output logic [N-1:0]      quotient
);
   localparam int CW = $clog2(N + 1);

   logic [N-1:0]  quo_ff, quo_in;
   logic [D:0]    rem_ff, rem_in;
   logic [D-1:0]  dvs_ff;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in, done_ff, done_in;
   logic [D:0]    rem_sh;
   logic [D+1:0]  diff;
   logic          ge;

   always_comb begin
      rem_sh  = {rem_ff[D-1:0], quo_ff[N-1]};
      diff    = {1'b0, rem_sh} - (D+2)'(dvs_ff);
      ge      = ~diff[D+1];
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         cnt_in  = CW'(N);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[N-2:0], ge};
         rem_in = ge ? diff[D:0] : rem_sh;
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      if (start) begin
         dvs_ff <= divisor;
      end
   end

   assign busy     = busy_ff;
   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule
`default_nettype wire

// File: hw/rtl/plc_sqrt.sv
`default_nettype none
// ----------------------------------------------------------------------------
// plc_sqrt
// Digit-by-digit integer square root, one root bit per cycle.
// ----------------------------------------------------------------------------
module plc_sqrt #(
   parameter int W = 48
) (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           start,
   input  wire logic [W-1:0]   radicand,
   output logic                done,
   output logic [W/2-1:0]      root
);
   localparam int R  = W / 2;
   localparam int RW = R + 4;
   localparam int CW = $clog2(R + 1);

   logic [W-1:0]  rad_ff, rad_in;
   logic [R-1:0]  root_ff, root_in;
   logic [RW-1:0] rem_ff, rem_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in, done_ff, done_in;
   logic [RW-1:0] rem_sh, trial;
   logic          ge;

   always_comb begin
      rem_sh  = {rem_ff[RW-3:0], rad_ff[W-1:W-2]};
      trial   = RW'({root_ff, 2'b01});
      ge      = rem_sh >= trial;
      rad_in  = rad_ff;
      root_in = root_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rad_in  = radicand;
         root_in = '0;
         rem_in  = '0;
         cnt_in  = CW'(R);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rad_in  = {rad_ff[W-3:0], 2'b00};
         root_in = {root_ff[R-2:0], ge};
         rem_in  = ge ? rem_sh - trial : rem_sh;
         cnt_in  = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rad_ff  <= rad_in;
      root_ff <= root_in;
      rem_ff  <= rem_in;
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule
`default_nettype wire

// File: hw/rtl/plc_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// plc_datapath
// Bin memories, configuration registers, arithmetic and result register.
// ----------------------------------------------------------------------------
module plc_datapath
   import plc_pkg::*;
#(
   parameter int BINS = BINS_DEFAULT
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               csr_valid,
   input  wire logic [CSR_A_W-1:0] csr_addr,
   input  wire logic [CSR_D_W-1:0] csr_data,
   input  wire logic [REQ_W-1:0]   req_tdata,
   input  wire logic [ACT_W-1:0]   req_tuser,
   input  wire plc_cmd_type        cmd,
   output plc_sts_type             sts,
   output logic [RSP_W-1:0]        rsp_tdata
);
   localparam int BIN_W = (BINS > 1) ? $clog2(BINS) : 1;
   localparam int OBS_W = $clog2(BINS + 1);
   localparam int SQ_W  = 47 + BIN_W;
   localparam int PB_W  = PHASE_W + BIN_W + 1;
   localparam int AW    = ((BIN_W > IDX_W) ? BIN_W : IDX_W) + 1;

   // configuration
   logic        [RATE_W-1:0]   rate_ff;
   logic signed [PROF_W-1:0]   lo_ff, hi_ff;
   logic        [SMOOTH_W-1:0] smooth_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff   <= '0;
         lo_ff     <= 24'sh800000;
         hi_ff     <= 24'sh7FFFFF;
         smooth_ff <= '0;
      end else if (csr_valid) begin
         case (csr_addr)
            CSR_RATE:   rate_ff   <= csr_data[RATE_W-1:0];
            CSR_LOW:    lo_ff     <= $signed(csr_data);
            CSR_HIGH:   hi_ff     <= $signed(csr_data);
            CSR_SMOOTH: smooth_ff <= csr_data[SMOOTH_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // request capture
   logic [PHASE_W-1:0] ph_in, ph_lim;
   logic [PB_W-1:0]    ph_prod, bin_raw;
   logic [BIN_W-1:0]   bin_in;

   always_comb begin
      ph_in   = req_tdata[PHASE_W-1:0];
      ph_lim  = (ph_in > PHASE_ONE) ? PHASE_ONE : ph_in;
      ph_prod = PB_W'(ph_lim) * PB_W'(BINS);
      bin_raw = ph_prod >> 16;
      bin_in  = (bin_raw > PB_W'(BINS - 1)) ? BIN_W'(BINS - 1) : bin_raw[BIN_W-1:0];
   end

   action_type               act_ff;
   logic        [BIN_W-1:0]  bin_ff;
   logic signed [ERR_W-1:0]  err_ff;
   logic        [IDX_W-1:0]  idx_ff;

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         act_ff <= req_tuser;
         bin_ff <= bin_in;
         err_ff <= $signed(req_tdata[PHASE_W+ERR_W-1:PHASE_W]);
         idx_ff <= req_tdata[PHASE_W+ERR_W+IDX_W-1:PHASE_W+ERR_W];
      end
   end

   logic [AW-1:0]    idx_w;
   logic             idx_ok;
   logic [BIN_W-1:0] idx_addr;

   always_comb begin
      idx_w    = AW'(idx_ff);
      idx_ok   = idx_w < AW'(BINS);
      idx_addr = idx_w[BIN_W-1:0];
   end

   // bin counter
   logic [BIN_W-1:0] cnt_ff;
   logic             cnt_last;

   assign cnt_last = cnt_ff == BIN_W'(BINS - 1);

   always_ff @(posedge clock) begin
      if (reset || cmd.cnt_clr) begin
         cnt_ff <= '0;
      end else if (cmd.cnt_inc) begin
         cnt_ff <= cnt_ff + 1'b1;
      end
   end

   // memories
   logic signed [PROF_W-1:0] prof_mem [BINS];
   logic signed [SUM_W-1:0]  sum_mem  [BINS];
   logic        [NUM_W-1:0]  num_mem  [BINS];
   logic signed [PROF_W-1:0] prof_rd_ff;
   logic signed [SUM_W-1:0]  sum_rd_ff;
   logic        [NUM_W-1:0]  num_rd_ff;

   logic [BIN_W-1:0] rd_addr;

   always_comb begin
      case (cmd.rd_sel)
         RD_BIN:  rd_addr = bin_ff;
         RD_IDX:  rd_addr = idx_addr;
         RD_CNT:  rd_addr = cnt_ff;
         RD_NEXT: rd_addr = cnt_last ? cnt_ff : cnt_ff + 1'b1;
         default: rd_addr = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         prof_rd_ff <= prof_mem[rd_addr];
         sum_rd_ff  <= sum_mem[rd_addr];
         num_rd_ff  <= num_mem[rd_addr];
      end
   end

   // profile update arithmetic
   logic signed [MEAN_W-1:0] mean_ff;
   logic signed [40:0]       prod_ff;
   logic        [47:0]       sq_ff;
   logic signed [47:0]       sq_full;
   logic signed [40:0]       rnd, stp;
   logic signed [27:0]       upd_v, lo_x, hi_x, clamp1, clamp2;
   logic signed [PROF_W-1:0] upd_res;

   always_comb begin
      sq_full = mean_ff * mean_ff;
      rnd     = prod_ff + 41'sd8192;
      stp     = rnd >>> 14;
      lo_x    = 28'(lo_ff);
      hi_x    = 28'(hi_ff);
      upd_v   = 28'(prof_rd_ff) + $signed(stp[27:0]);
      clamp1  = (upd_v < lo_x) ? lo_x : upd_v;
      clamp2  = (clamp1 > hi_x) ? hi_x : clamp1;
      upd_res = clamp2[PROF_W-1:0];
   end

   // smoothing arithmetic
   logic signed [PROF_W-1:0] prv_ff, cur_ff, nxt_ff;
   logic signed [41:0]       ka_ff, sb_ff;
   logic        [16:0]       keep;
   logic signed [24:0]       pair;
   logic signed [43:0]       blend;
   logic signed [PROF_W-1:0] sm_res;

   always_comb begin
      keep   = 17'h10000 - 17'(smooth_ff);
      pair   = 25'(prv_ff) + 25'(prof_rd_ff);
      blend  = (44'(ka_ff) <<< 1) + 44'(sb_ff) + 44'sd65536;
      sm_res = blend[40:17];
   end

   always_ff @(posedge clock) begin
      if (cmd.sm_init) begin
         prv_ff <= prof_rd_ff;
         cur_ff <= prof_rd_ff;
      end else if (cmd.wr_smooth) begin
         prv_ff <= cur_ff;
         cur_ff <= nxt_ff;
      end
      if (cmd.sm_mul) begin
         nxt_ff <= prof_rd_ff;
         ka_ff  <= $signed({1'b0, keep}) * cur_ff;
         sb_ff  <= $signed({1'b0, smooth_ff}) * pair;
      end
   end

   // memory writes
   logic                     acc_ok, prof_we, acc_we;
   logic [BIN_W-1:0]         acc_addr;
   logic signed [PROF_W-1:0] prof_wd;
   logic signed [SUM_W-1:0]  sum_wd;
   logic [NUM_W-1:0]         num_wd;

   always_comb begin
      acc_ok   = num_rd_ff != '1;
      prof_we  = cmd.wr_wipe | cmd.wr_upd | cmd.wr_smooth;
      acc_we   = cmd.wr_wipe | cmd.wr_zero | (cmd.wr_acc & acc_ok);
      acc_addr = cmd.wr_acc ? bin_ff : cnt_ff;
      if (cmd.wr_upd) begin
         prof_wd = upd_res;
      end else if (cmd.wr_smooth) begin
         prof_wd = sm_res;
      end else begin
         prof_wd = '0;
      end
      if (cmd.wr_acc) begin
         sum_wd = sum_rd_ff + SUM_W'(err_ff);
         num_wd = num_rd_ff + 1'b1;
      end else begin
         sum_wd = '0;
         num_wd = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (prof_we) begin
         prof_mem[cnt_ff] <= prof_wd;
      end
      if (acc_we) begin
         sum_mem[acc_addr] <= sum_wd;
         num_mem[acc_addr] <= num_wd;
      end
   end

   // mean and norm division
   logic              neg;
   logic [SUM_W-1:0]  sum_mag;
   logic [SQ_W-1:0]   sq_acc_ff, div_dvd, quotient;
   logic [OBS_W-1:0]  obs_ff;
   logic [NUM_W-1:0]  div_dvs;
   logic              div_busy, div_done, sqrt_done;
   logic [SQRT_W/2-1:0] root;
   logic [MEAN_W-1:0] q_lo;

   always_comb begin
      neg     = sum_rd_ff[SUM_W-1];
      sum_mag = neg ? SUM_W'(-sum_rd_ff) : SUM_W'(sum_rd_ff);
      div_dvd = cmd.div_norm ? sq_acc_ff : SQ_W'(sum_mag);
      div_dvs = cmd.div_norm ? NUM_W'(obs_ff) : num_rd_ff;
      q_lo    = quotient[MEAN_W-1:0];
   end

   plc_divider #(
      .N(SQ_W),
      .D(NUM_W)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_dvd),
      .divisor  (div_dvs),
      .busy     (div_busy),
      .done     (div_done),
      .quotient (quotient)
   );

   plc_sqrt #(
      .W(SQRT_W)
   ) u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.sqrt_start),
      .radicand (quotient[SQRT_W-1:0]),
      .done     (sqrt_done),
      .root     (root)
   );

   always_ff @(posedge clock) begin
      if (cmd.mean_load) begin
         mean_ff <= neg ? -$signed(q_lo) : $signed(q_lo);
      end
      if (cmd.mul_load) begin
         prod_ff <= $signed({1'b0, rate_ff}) * mean_ff;
         sq_ff   <= unsigned'(sq_full);
      end
      if (cmd.acc_clr) begin
         sq_acc_ff <= '0;
         obs_ff    <= '0;
      end else if (cmd.wr_upd) begin
         sq_acc_ff <= sq_acc_ff + SQ_W'(sq_ff);
         obs_ff    <= obs_ff + 1'b1;
      end
   end

   // iteration state
   logic [NORM_W-1:0] norm_ff;
   logic [ITER_W-1:0] iter_ff;
   logic              rec_ff;

   always_ff @(posedge clock) begin
      if (reset || cmd.state_clr) begin
         norm_ff <= '0;
         iter_ff <= '0;
         rec_ff  <= 1'b0;
      end else begin
         if (cmd.norm_load) begin
            norm_ff <= (root > (SQRT_W/2)'(NORM_MAX)) ? NORM_MAX : root[NORM_W-1:0];
         end
         if (cmd.iter_inc) begin
            iter_ff <= iter_ff + 1'b1;
         end
         if (cmd.rec_set) begin
            rec_ff <= 1'b1;
         end else if (cmd.rec_clr) begin
            rec_ff <= 1'b0;
         end
      end
   end

   // result beat
   logic [PROF_W-1:0] corr;
   logic [RSP_W-1:0]  rsp_ff;

   assign corr = ((act_ff == ACT_QUERY) || ((act_ff == ACT_READ) && idx_ok)) ?
                 prof_rd_ff : '0;

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_ff <= {rec_ff, iter_ff, norm_ff, corr};
      end
   end

   assign rsp_tdata = rsp_ff;

   always_comb begin
      sts.act       = act_ff;
      sts.recording = rec_ff;
      sts.cnt_last  = cnt_last;
      sts.num_zero  = num_rd_ff == '0;
      sts.obs_zero  = obs_ff == '0;
      sts.smooth_on = (smooth_ff != '0) && (BINS > 2);
      sts.div_busy  = div_busy;
      sts.div_done  = div_done;
      sts.sqrt_done = sqrt_done;
   end

endmodule
`default_nettype wire

// File: hw/rtl/plc_controller.sv
`default_nettype none
// ----------------------------------------------------------------------------
// plc_controller
// Sequencer for actions, bin sweeps and the end-of-iteration walk.
// ----------------------------------------------------------------------------
module plc_controller
   import plc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire plc_sts_type sts,
   output plc_cmd_type      cmd
);
   typedef enum logic [20:0] {
      S_WIPE = 21'd1 << 0,
      S_IDLE = 21'd1 << 1,
      S_DISP = 21'd1 << 2,
      S_ZERO = 21'd1 << 3,
      S_SRD  = 21'd1 << 4,
      S_SWR  = 21'd1 << 5,
      S_QRD  = 21'd1 << 6,
      S_ERD  = 21'd1 << 7,
      S_ECHK = 21'd1 << 8,
      S_EDIV = 21'd1 << 9,
      S_EMUL = 21'd1 << 10,
      S_EUPD = 21'd1 << 11,
      S_NCHK = 21'd1 << 12,
      S_NDIV = 21'd1 << 13,
      S_NSQR = 21'd1 << 14,
      S_SCHK = 21'd1 << 15,
      S_MRD0 = 21'd1 << 16,
      S_MINI = 21'd1 << 17,
      S_MRD  = 21'd1 << 18,
      S_MMUL = 21'd1 << 19,
      S_MWR  = 21'd1 << 20
   } state_type;

   state_type state_ff, state_in;
   logic      owe_ff, owe_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      owe_in       = owe_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      cmd          = '0;
      cmd.rd_sel   = RD_CNT;
      req_tready   = 1'b0;

      case (state_ff)
         S_WIPE: begin
            cmd.wr_wipe = 1'b1;
            if (sts.cnt_last) begin
               cmd.cnt_clr = 1'b1;
               state_in    = S_IDLE;
            end else begin
               cmd.cnt_inc = 1'b1;
            end
         end
         S_IDLE: begin
            if (owe_ff) begin
               if (!rsp_valid_ff || rsp_tready) begin
                  cmd.rsp_load = 1'b1;
                  rsp_valid_in = 1'b1;
                  owe_in       = 1'b0;
               end
            end else begin
               req_tready = 1'b1;
               if (req_tvalid) begin
                  cmd.load_req = 1'b1;
                  state_in     = S_DISP;
               end
            end
         end
         S_DISP: begin
            owe_in   = 1'b1;
            state_in = S_IDLE;
            case (sts.act)
               ACT_BEGIN: begin
                  cmd.rec_set = 1'b1;
                  cmd.cnt_clr = 1'b1;
                  state_in    = S_ZERO;
               end
               ACT_SAMPLE: begin
                  if (sts.recording) begin
                     state_in = S_SRD;
                  end
               end
               ACT_DISCARD: begin
                  cmd.rec_clr = 1'b1;
               end
               ACT_END: begin
                  if (sts.recording) begin
                     cmd.cnt_clr = 1'b1;
                     cmd.acc_clr = 1'b1;
                     state_in    = S_ERD;
                  end
               end
               ACT_QUERY, ACT_READ: begin
                  state_in = S_QRD;
               end
               ACT_CLEAR: begin
                  cmd.state_clr = 1'b1;
                  cmd.cnt_clr   = 1'b1;
                  state_in      = S_WIPE;
               end
               default: begin
               end
            endcase
         end
         S_ZERO: begin
            cmd.wr_zero = 1'b1;
            if (sts.cnt_last) begin
               cmd.cnt_clr = 1'b1;
               state_in    = S_IDLE;
            end else begin
               cmd.cnt_inc = 1'b1;
            end
         end
         S_SRD: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_BIN;
            state_in   = S_SWR;
         end
         S_SWR: begin
            cmd.wr_acc = 1'b1;
            state_in   = S_IDLE;
         end
         S_QRD: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = (sts.act == ACT_QUERY) ? RD_BIN : RD_IDX;
            state_in   = S_IDLE;
         end
         S_ERD: begin
            cmd.rd_en = 1'b1;
            state_in  = S_ECHK;
         end
         S_ECHK: begin
            if (sts.num_zero) begin
               if (sts.cnt_last) begin
                  cmd.cnt_clr = 1'b1;
                  state_in    = S_NCHK;
               end else begin
                  cmd.cnt_inc = 1'b1;
                  state_in    = S_ERD;
               end
            end else begin
               cmd.div_start = 1'b1;
               state_in      = S_EDIV;
            end
         end
         S_EDIV: begin
            if (sts.div_done) begin
               cmd.mean_load = 1'b1;
               state_in      = S_EMUL;
            end
         end
         S_EMUL: begin
            cmd.mul_load = 1'b1;
            state_in     = S_EUPD;
         end
         S_EUPD: begin
            cmd.wr_upd = 1'b1;
            if (sts.cnt_last) begin
               cmd.cnt_clr = 1'b1;
               state_in    = S_NCHK;
            end else begin
               cmd.cnt_inc = 1'b1;
               state_in    = S_ERD;
            end
         end
         S_NCHK: begin
            if (sts.obs_zero) begin
               state_in = S_SCHK;
            end else begin
               cmd.div_start = 1'b1;
               cmd.div_norm  = 1'b1;
               state_in      = S_NDIV;
            end
         end
         S_NDIV: begin
            if (sts.div_done) begin
               cmd.sqrt_start = 1'b1;
               state_in       = S_NSQR;
            end
         end
         S_NSQR: begin
            if (sts.sqrt_done) begin
               cmd.norm_load = 1'b1;
               state_in      = S_SCHK;
            end
         end
         S_SCHK: begin
            if (sts.smooth_on) begin
               state_in = S_MRD0;
            end else begin
               cmd.iter_inc = 1'b1;
               cmd.rec_clr  = 1'b1;
               state_in     = S_IDLE;
            end
         end
         S_MRD0: begin
            cmd.rd_en = 1'b1;
            state_in  = S_MINI;
         end
         S_MINI: begin
            cmd.sm_init = 1'b1;
            state_in    = S_MRD;
         end
         S_MRD: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_NEXT;
            state_in   = S_MMUL;
         end
         S_MMUL: begin
            cmd.sm_mul = 1'b1;
            state_in   = S_MWR;
         end
         S_MWR: begin
            cmd.wr_smooth = 1'b1;
            if (sts.cnt_last) begin
               cmd.cnt_clr  = 1'b1;
               cmd.iter_inc = 1'b1;
               cmd.rec_clr  = 1'b1;
               state_in     = S_IDLE;
            end else begin
               cmd.cnt_inc = 1'b1;
               state_in    = S_MRD;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_WIPE;
         owe_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         owe_ff       <= owe_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

   a_div_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |-> !sts.div_busy)
      else $error("divider started while busy");

   a_rsp_free: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> (!rsp_valid_ff || rsp_tready))
      else $error("result overwritten before taken");

   a_accept_disp: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == S_DISP))
      else $error("accepted beat not dispatched");

   a_div_wait: assert property (@(posedge clock) disable iff (reset)
      sts.div_done |-> (state_ff == S_EDIV || state_ff == S_NDIV))
      else $error("divider result not awaited");

endmodule
`default_nettype wire

// File: hw/rtl/phase_binned_learning_controller.sv
`default_nettype none
// ----------------------------------------------------------------------------
// phase_binned_learning_controller
// Iterative learning control over BINS phase bins, one result beat per request.
// ----------------------------------------------------------------------------
// Requests are handled one at a time. Discard, unused and out-of-recording
// actions go straight back to idle, the two queries make one memory read
// and sample one read-modify-write. Begin and clear sweep every bin. End
// walks all bins: empty bins are skipped, each observed bin takes a
// bit-serial division for its mean; then one more division and a square
// root for the RMS, and a smoothing pass over the bins when enabled. After
// reset a clearing pass over every bin runs before the first request is
// taken. The result register lets a new request be taken while the
// previous result waits.
// ----------------------------------------------------------------------------
module phase_binned_learning_controller
   import plc_pkg::*;
#(
   parameter int BINS = BINS_DEFAULT
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [CSR_A_W-1:0] csr_addr,
   input  wire logic [CSR_D_W-1:0] csr_data,
   input  wire logic               req_tvalid,
   output logic                    req_tready,
   // phase[16:0], error_value[40:17], bin_index[46:41], zero[47]
   input  wire logic [REQ_W-1:0]   req_tdata,
   // action[2:0]
   input  wire logic [ACT_W-1:0]   req_tuser,
   output logic                    rsp_tvalid,
   input  wire logic               rsp_tready,
   // correction_value[23:0], error_norm[46:24], iterations_done[78:47],
   // is_recording[79]
   output logic [RSP_W-1:0]        rsp_tdata
);
   plc_cmd_type cmd;
   plc_sts_type sts;

   assign csr_ready = 1'b1;

   plc_controller u_controller (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   plc_datapath #(
      .BINS(BINS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_addr  (csr_addr),
      .csr_data  (csr_data),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_tdata (rsp_tdata)
   );

endmodule
`default_nettype wire

// File: dv/phase_binned_learning_controller_tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// phase_binned_learning_controller_tb
// Self-checking bench: a directed table and then random begin/sample/end
// sessions with noise. Each request beat is predicted by an in-bench model of
// the bins and their corrections. Response beats are checked field by field.
// Both stream sides idle at random. The response side also holds off once for a
// long stretch. The registers are reprogrammed between phases, extremes included.
// ----------------------------------------------------------------------------
module phase_binned_learning_controller_tb;
   import plc_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int         NBINS      = 64;
   localparam longint     CYCLE_CAP  = 30000000;
   localparam action_type ACT_UNUSED = 3'd7;

   typedef struct {
      action_type       act;
      logic [16:0]      phase;
      logic [23:0]      err;
      logic [5:0]       idx;
   } req_type;

   typedef struct {
      logic [23:0] corr;
      logic [22:0] norm;
      logic [31:0] iter;
      logic        rec;
   } result_type;

   typedef struct {
      req_type    rq;
      bit         typed;
      result_type res;
   } row_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [CSR_A_W-1:0] csr_addr = '0;
   logic [CSR_D_W-1:0] csr_data = '0;
   logic               req_tvalid = 1'b0;
   logic               req_tready;
   logic [REQ_W-1:0]   req_tdata = '0;
   logic [ACT_W-1:0]   req_tuser = '0;
   logic               rsp_tvalid;
   logic               rsp_tready = 1'b0;
   logic [RSP_W-1:0]   rsp_tdata;

   phase_binned_learning_controller dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predicted block state
   longint          gain, low_lim, high_lim, blend;
   longint          corr_bin [NBINS];
   longint          err_sum [NBINS];
   longint          err_cnt [NBINS];
   longint          norm_q, iter_q;
   bit              rec_q;

   result_type      pending_q [$];
   int              errors = 0;
   int              sent = 0;
   int              send_gap = 0;
   int              recv_gap = 0;
   int              recv_hold = 0;
   longint          cycles = 0;
   row_type         dir_q [$];

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_CAP) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   task automatic report(input string what, input longint got, input longint want);
      errors++;
      $display("mismatch %s: got %0h expected %0h", what, got, want);
   endtask

   function automatic int phase_to_bin(logic [16:0] ph);
      longint p, b;
      p = ph > 65536 ? 65536 : ph;
      b = (p * NBINS) >>> 16;
      return b > NBINS - 1 ? NBINS - 1 : int'(b);
   endfunction

   function automatic longint clamp_corr(longint v);
      if (v < low_lim) v = low_lim;
      if (v > high_lim) v = high_lim;
      return v;
   endfunction

   function automatic longint unsigned int_root(longint unsigned x);
      longint unsigned r, b;
      r = 0;
      b = 64'h4000_0000_0000_0000;
      while (b > x) b >>= 2;
      while (b != 0) begin
         if (x >= r + b) begin
            x -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   function automatic void wipe_state();
      for (int i = 0; i < NBINS; i++) begin
         corr_bin[i] = 0;
         err_sum[i] = 0;
         err_cnt[i] = 0;
      end
      norm_q = 0;
      iter_q = 0;
      rec_q = 0;
   endfunction

   function automatic void close_iteration();
      longint unsigned sq, seen, r;
      longint mean, stp, t;
      longint prior [NBINS];
      int pv, nx;
      sq = 0;
      seen = 0;
      rec_q = 0;
      for (int i = 0; i < NBINS; i++) begin
         if (err_cnt[i] != 0) begin
            mean = err_sum[i] / err_cnt[i];
            sq += mean * mean;
            seen++;
            stp = (gain * mean + 8192) >>> 14;
            corr_bin[i] = clamp_corr(corr_bin[i] + stp);
         end
      end
      if (seen > 0) begin
         r = int_root(sq / seen);
         norm_q = r > 8388607 ? 8388607 : r;
      end
      if (blend != 0) begin
         prior = corr_bin;
         for (int i = 0; i < NBINS; i++) begin
            pv = i == 0 ? 0 : i - 1;
            nx = i + 1 >= NBINS ? NBINS - 1 : i + 1;
            t = (65536 - blend) * 2 * prior[i] + blend * (prior[pv] + prior[nx]) + 65536;
            corr_bin[i] = t >>> 17;
         end
      end
      iter_q = (iter_q + 1) & 64'hFFFF_FFFF;
   endfunction

   function automatic result_type predict_beat(req_type rq);
      result_type res;
      longint corr;
      int b;
      corr = 0;
      case (rq.act)
         ACT_BEGIN: begin
            for (int i = 0; i < NBINS; i++) begin
               err_sum[i] = 0;
               err_cnt[i] = 0;
            end
            rec_q = 1;
         end
         ACT_SAMPLE: begin
            if (rec_q) begin
               b = phase_to_bin(rq.phase);
               if (err_cnt[b] < 65535) begin
                  err_sum[b] += longint'($signed(rq.err));
                  err_cnt[b]++;
               end
            end
         end
         ACT_DISCARD: rec_q = 0;
         ACT_END: if (rec_q) close_iteration();
         ACT_QUERY: corr = corr_bin[phase_to_bin(rq.phase)];
         ACT_READ: if (rq.idx < NBINS) corr = corr_bin[rq.idx];
         ACT_CLEAR: wipe_state();
         default: ;
      endcase
      res.corr = corr[23:0];
      res.norm = norm_q[22:0];
      res.iter = iter_q[31:0];
      res.rec = rec_q;
      return res;
   endfunction

   task automatic write_reg(input csr_addr_type a, input longint v);
      csr_addr <= a;
      csr_data <= v[23:0];
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      case (a)
         CSR_RATE: gain = v & 16'hFFFF;
         CSR_LOW: low_lim = longint'($signed(v[23:0]));
         CSR_HIGH: high_lim = longint'($signed(v[23:0]));
         CSR_SMOOTH: blend = v & 16'hFFFF;
         default: ;
      endcase
   endtask

   task automatic program_regs(input longint r, input longint lo, input longint hi,
                               input longint s);
      write_reg(CSR_RATE, r);
      write_reg(CSR_LOW, lo);
      write_reg(CSR_HIGH, hi);
      write_reg(CSR_SMOOTH, s);
   endtask

   task automatic send_beat(input req_type rq, input bit typed, input result_type want);
      int gap;
      result_type res;
      gap = $urandom_range(0, send_gap);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tuser <= rq.act;
      req_tdata <= {1'b0, rq.idx, rq.err, rq.phase};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      res = predict_beat(rq);
      pending_q.push_back(typed ? want : res);
      sent++;
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_q.size() != 0) @(posedge clock);
   endtask

   function automatic req_type any_req(action_type a);
      req_type rq;
      rq.act = a;
      rq.phase = ($urandom_range(0, 7) == 0) ? 17'($urandom) : 17'($urandom_range(0, 65536));
      rq.err = ($urandom_range(0, 2) == 0) ? 24'($urandom)
                                          : 24'($signed($urandom_range(0, 8000)) - 4000);
      rq.idx = 6'($urandom);
      return rq;
   endfunction

   task automatic random_session();
      result_type none;
      int n;
      none = '{default: '0};
      if ($urandom_range(0, 6) == 0) begin
         send_beat(any_req(action_type'($urandom_range(0, 7))), 0, none);
         return;
      end
      send_beat(any_req(ACT_BEGIN), 0, none);
      n = $urandom_range(1, 30);
      for (int k = 0; k < n; k++) begin
         case ($urandom_range(0, 9))
            0: send_beat(any_req(ACT_QUERY), 0, none);
            1: send_beat(any_req(ACT_READ), 0, none);
            default: send_beat(any_req(ACT_SAMPLE), 0, none);
         endcase
      end
      send_beat(any_req($urandom_range(0, 9) == 0 ? ACT_DISCARD : ACT_END), 0, none);
      for (int k = 0; k < 3; k++)
         send_beat(any_req($urandom_range(0, 1) ? ACT_READ : ACT_QUERY), 0, none);
   endtask

   task automatic random_phase(input int beats);
      int start;
      start = sent;
      while (sent - start < beats) random_session();
   endtask

   // response side
   initial begin
      int gap;
      result_type want;
      logic [RSP_W-1:0] d;
      @(negedge reset);
      @(posedge clock);
      forever begin
         gap = recv_hold > 0 ? recv_hold : $urandom_range(0, recv_gap);
         recv_hold = 0;
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         d = rsp_tdata;
         if (pending_q.size() == 0) begin
            report("unexpected beat", longint'(d[63:0]), 0);
         end else begin
            want = pending_q.pop_front();
            if (d[23:0] !== want.corr)
               report("correction_value", longint'(d[23:0]), longint'(want.corr));
            if (d[46:24] !== want.norm)
               report("error_norm", longint'(d[46:24]), longint'(want.norm));
            if (d[78:47] !== want.iter)
               report("iterations_done", longint'(d[78:47]), longint'(want.iter));
            if (d[79] !== want.rec)
               report("is_recording", longint'(d[79]), longint'(want.rec));
         end
      end
   end

   initial begin
      result_type z, r1;
      z = '{default: '0};
      r1 = z;
      r1.rec = 1'b1;
      gain = 0;
      low_lim = -8388608;
      high_lim = 8388607;
      blend = 0;
      wipe_state();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      program_regs(65535, -8388608, 8388607, 0);
      dir_q.push_back('{'{ACT_READ, 17'd0, 24'd0, 6'd0}, 1, z});
      dir_q.push_back('{'{ACT_READ, 17'd0, 24'd0, 6'd63}, 1, z});
      dir_q.push_back('{'{ACT_QUERY, 17'h10000, 24'd0, 6'd0}, 1, z});
      dir_q.push_back('{'{ACT_SAMPLE, 17'd5, 24'h7FFFFF, 6'd0}, 1, z});
      dir_q.push_back('{'{ACT_END, 17'd0, 24'd0, 6'd0}, 1, z});
      dir_q.push_back('{'{ACT_DISCARD, 17'd0, 24'd0, 6'd0}, 1, z});
      dir_q.push_back('{'{ACT_UNUSED, 17'h1FFFF, 24'hFFFFFF, 6'h3F}, 1, z});
      dir_q.push_back('{'{ACT_BEGIN, 17'd0, 24'd0, 6'd0}, 1, r1});
      dir_q.push_back('{'{ACT_BEGIN, 17'd0, 24'd0, 6'd0}, 1, r1});
      dir_q.push_back('{'{ACT_SAMPLE, 17'd0, 24'h800000, 6'd0}, 0, z});
      dir_q.push_back('{'{ACT_SAMPLE, 17'h10000, 24'h7FFFFF, 6'd0}, 0, z});
      dir_q.push_back('{'{ACT_SAMPLE, 17'h1FFFF, 24'd1, 6'd0}, 0, z});
      dir_q.push_back('{'{ACT_SAMPLE, 17'h08000, 24'd5, 6'd0}, 0, z});
      dir_q.push_back('{'{ACT_SAMPLE, 17'h0FFFF, 24'hFFFFFE, 6'd0}, 0, z});
      dir_q.push_back('{'{ACT_END, 17'd0, 24'd0, 6'd0}, 0, z});
      dir_q.push_back('{'{ACT_QUERY, 17'd0, 24'd0, 6'd0}, 0, z});
      dir_q.push_back('{'{ACT_QUERY, 17'h1FFFF, 24'd0, 6'd0}, 0, z});
      dir_q.push_back('{'{ACT_READ, 17'd0, 24'd0, 6'd32}, 0, z});
      dir_q.push_back('{'{ACT_BEGIN, 17'd0, 24'd0, 6'd0}, 0, z});
      dir_q.push_back('{'{ACT_DISCARD, 17'd0, 24'd0, 6'd0}, 0, z});
      dir_q.push_back('{'{ACT_END, 17'd0, 24'd0, 6'd0}, 0, z});
      dir_q.push_back('{'{ACT_CLEAR, 17'd0, 24'd0, 6'd0}, 1, z});
      dir_q.push_back('{'{ACT_READ, 17'd0, 24'd0, 6'd63}, 1, z});
      foreach (dir_q[i]) send_beat(dir_q[i].rq, dir_q[i].typed, dir_q[i].res);
      drain();

      send_gap = 18;
      recv_gap = 18;
      program_regs(0, -8388608, 8388607, 0);
      random_phase(250);
      drain();
      program_regs(65535, -8388608, 8388607, 65535);
      random_phase(250);
      drain();
      program_regs(16384, -1000, 1000, 32768);
      send_gap = 0;
      recv_hold = 400;
      random_phase(250);
      drain();
      send_gap = 18;
      recv_gap = 0;
      program_regs(8000, 5000, -5000, 1000);
      random_phase(250);
      drain();
      recv_gap = 18;
      for (int p = 0; p < 3; p++) begin
         send_gap = p == 1 ? 0 : 18;
         recv_gap = p == 2 ? 0 : 18;
         program_regs($urandom_range(0, 65535), $urandom_range(0, 16777215),
                      $urandom_range(0, 16777215), $urandom_range(0, 65535));
         if (p == 0) send_beat(any_req(ACT_CLEAR), 0, z);
         random_phase(200);
         drain();
      end

      repeat (50) @(posedge clock);
      if (errors == 0 && pending_q.size() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
`default_nettype wire

// File: filelist.f
hw/rtl/plc_pkg.sv
hw/rtl/plc_divider.sv
hw/rtl/plc_sqrt.sv
hw/rtl/plc_datapath.sv
hw/rtl/plc_controller.sv
hw/rtl/phase_binned_learning_controller.sv
dv/phase_binned_learning_controller_tb.sv
